@@ rtl/stq_pkg.sv @@
// Package with the request and result types and the result kind codes of the timer queue.
package stq_pkg;

  localparam int TimeW = 52;
  localparam int PerW  = 40;
  localparam int IdW   = 8;

  localparam logic [1:0] KindAdded    = 2'd0;
  localparam logic [1:0] KindRejected = 2'd1;
  localparam logic [1:0] KindExpired  = 2'd2;
  localparam logic [1:0] KindNone     = 2'd3;

  localparam logic ActAdd  = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef struct packed {
    logic             action;
    logic [IdW-1:0]   timer_id;
    logic [TimeW-1:0] expire_time;
    logic [PerW-1:0]  repeat_interval;
    logic [TimeW-1:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IdW-1:0]   timer_id_res;
    logic [TimeW-1:0] due_time;
    logic             rearmed;
    logic             new_earliest;
    logic [TimeW-1:0] earliest_time;
    logic             queue_empty;
    logic             is_last;
  } res_t;

  // One queue entry as it moves between cells.
  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] due;
    logic [PerW-1:0]  period;
  } entry_t;

  // Sort order: valid entries first, then by due time, then by id.
  function automatic logic before_f(entry_t a, entry_t b);
    if (a.valid != b.valid) return a.valid;
    if (!a.valid) return 1'b0;
    if (a.due != b.due) return a.due < b.due;
    return a.id < b.id;
  endfunction

endpackage

@@ rtl/stq_cell.sv @@
// One cell of the sorted chain: holds an entry and takes part in insert and head pop.
module stq_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              ins,     // insertion of ins_e into the chain
  input  logic              pop,     // head removed, chain shifts toward the head
  input  stq_pkg::entry_t   ins_e,
  input  stq_pkg::entry_t   left,    // neighbor nearer the head
  input  stq_pkg::entry_t   right,   // neighbor farther from the head
  input  logic              left_goes, // left neighbor is pushed down here
  output stq_pkg::entry_t   cur,
  output logic              goes       // this entry is pushed down
);
  stq_pkg::entry_t ent;
  logic valid;

  assign cur = '{valid: valid, id: ent.id, due: ent.due, period: ent.period};
  assign goes = ins && stq_pkg::before_f(ins_e, cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= right.valid;
    end else if (ins && goes) begin
      // An empty neighbor pushed down here leaves this cell empty.
      valid <= left_goes ? left.valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent <= right;
    end else if (ins && goes) begin
      ent <= left_goes ? left : ins_e;
    end
  end
endmodule

@@ rtl/sorted_timer_queue.sv @@
// Top level of the sorted timer queue: a chain of cells kept in (due, id) order.
//
// Usage: drive a request on req with start high; it is taken at the rising edge
// where busy is low. An add (action 0) inserts a timer with an id, a due time
// and a repeat period; one result comes back. A tick (action 1) with the current
// time emits every timer due at or before that time in (due, id) order, one
// result per cycle, with is_last on the final one; with nothing due it gives one
// result of kind 3. Results appear on res for one cycle, marked by res_valid;
// the receiver cannot stall, so no result is ever held.
//
// Timing: the chain keeps the earliest entry at its head. An add checks for a
// duplicate id and shifts the chain in the same cycle, and its result follows
// in the next. A tick alternates a pop state and an emit state while the head
// is due, then re-inserts each periodic timer, then replays the results once
// the final earliest time is known.
//
// Reset empties the queue; no clearing pass is needed since each cell has a
// valid flag.
module sorted_timer_queue #(
  parameter int CAPACITY = 64,
  parameter int ID_BITS  = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  stq_pkg::req_t   req,
  output logic            res_valid,
  output stq_pkg::res_t   res
);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SAddCk = 3'd1;
  localparam logic [2:0] SPop   = 3'd2;
  localparam logic [2:0] SEmit  = 3'd3;
  localparam logic [2:0] SReins = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0] state, state_next;
  stq_pkg::req_t rq;
  stq_pkg::entry_t cells [CAPACITY];
  logic goes [CAPACITY];
  stq_pkg::entry_t ins_e;
  logic ins, pop;
  logic acc;
  logic [CW-1:0] count;
  logic [CW-1:0] nre;       // re-armed timers parked
  stq_pkg::entry_t park [CAPACITY];
  stq_pkg::entry_t hold;    // popped head awaiting its result
  logic dup;
  logic [stq_pkg::TimeW:0] sum;
  logic [stq_pkg::TimeW-1:0] nd;

  // Entries are masked to ID_BITS on the way in.
  logic [stq_pkg::IdW-1:0] id_m;
  assign id_m = rq.timer_id & stq_pkg::IdW'((1 << ID_BITS) - 1);

  // A request is taken only while the block is idle.
  assign acc = start && !busy;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    stq_pkg::entry_t lft, rgt;
    logic lg;
    assign lft = (i == 0) ? ins_e : cells[(i == 0) ? 0 : i-1];
    assign lg  = (i == 0) ? 1'b0 : goes[(i == 0) ? 0 : i-1];
    assign rgt = (i == CAPACITY-1) ? '0 : cells[(i == CAPACITY-1) ? i : i+1];
    stq_cell u_cell (
      .clk(clk), .rst(rst), .ins(ins), .pop(pop), .ins_e(ins_e),
      .left(lft), .right(rgt), .left_goes(lg), .cur(cells[i]), .goes(goes[i])
    );
  end

  // Duplicate check: each cell compares its id in parallel.
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cells[i].valid && cells[i].id == id_m) dup = 1'b1;
    end
  end

  // Re-arm time, clamped to the top of the time range.
  assign sum = {1'b0, rq.now} + {{(stq_pkg::TimeW-stq_pkg::PerW+1){1'b0}}, hold.period};
  assign nd = sum[stq_pkg::TimeW] ? '1 : sum[stq_pkg::TimeW-1:0];

  always_comb begin
    state_next = state;
    ins = 1'b0;
    pop = 1'b0;
    ins_e = '0;
    case (state)
      SIdle:  if (acc) state_next = (req.action == stq_pkg::ActAdd) ? SAddCk : SPop;
      SAddCk: begin
        if (!dup && count != CW'(CAPACITY)) begin
          ins = 1'b1;
          ins_e = '{valid: 1'b1, id: id_m, due: rq.expire_time, period: rq.repeat_interval};
        end
        state_next = SIdle;
      end
      SPop: begin
        if (cells[0].valid && cells[0].due <= rq.now) begin
          pop = 1'b1;
          state_next = SEmit;
        end else begin
          state_next = (nre != '0) ? SReins : SDone;
        end
      end
      SEmit:  state_next = SPop;
      SReins: begin
        ins = 1'b1;
        ins_e = park[0];
        if (nre == CW'(1)) state_next = SDone;
      end
      SDone:  state_next = SIdle;
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      count <= '0;
      nre <= '0;
    end else begin
      state <= state_next;
      if (ins && state == SAddCk) count <= count + 1'b1;
      if (pop && cells[0].period == '0) count <= count - 1'b1;
      if (pop && cells[0].period != '0) nre <= nre + 1'b1;
      if (state == SReins) nre <= nre - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) rq <= req;
    if (pop) hold <= cells[0];
  end

  // Re-armed timers wait in a stack until the pops are done. Re-armed timers
  // go back only after the last pop, so none is popped twice in this tick.
  always_ff @(posedge clk) begin
    if (state == SEmit && hold.period != '0) begin
      park[0] <= '{valid: 1'b1, id: hold.id, due: nd, period: hold.period};
      for (int i = 1; i < CAPACITY; i++) park[i] <= park[i-1];
    end else if (state == SReins) begin
      for (int i = 0; i < CAPACITY-1; i++) park[i] <= park[i+1];
      park[CAPACITY-1] <= '0;
    end
  end

  // Expired results cannot report earliest_time until the tick ends, so
  // they are stored in order and replayed from the front of a shift buffer.
  // The valid bit of a stored entry carries the rearmed flag.
  stq_pkg::entry_t rbuf [CAPACITY];
  logic [CW-1:0] rcnt;
  always_ff @(posedge clk) begin
    if (state == SEmit) begin
      rbuf[rcnt[$clog2(CAPACITY)-1:0]] <= '{valid: hold.period != '0,
        id: hold.id, due: hold.due, period: '0};
    end else if (rstate == RPlay) begin
      for (int i = 0; i < CAPACITY-1; i++) rbuf[i] <= rbuf[i+1];
    end
  end

  logic [2:0] rstate;
  localparam logic [2:0] RIdle = 3'd0;
  localparam logic [2:0] RPlay = 3'd1;
  logic [stq_pkg::TimeW-1:0] et_l;
  logic emp_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
      rstate <= RIdle;
    end else begin
      case (rstate)
        RIdle: begin
          if (state == SEmit) rcnt <= rcnt + 1'b1;
          if (state == SDone && rcnt != '0) rstate <= RPlay;
        end
        RPlay: begin
          rcnt <= rcnt - 1'b1;
          if (rcnt == CW'(1)) rstate <= RIdle;
        end
        default: rstate <= RIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == SDone) begin
      et_l <= cells[0].valid ? cells[0].due : '0;
      emp_l <= !cells[0].valid;
    end
  end

  // Add results and the empty-tick result.
  logic add_r, tick0_r;
  stq_pkg::res_t add_res;
  always_ff @(posedge clk) begin
    if (rst) begin
      add_r <= 1'b0;
      tick0_r <= 1'b0;
    end else begin
      add_r <= (state == SAddCk);
      tick0_r <= (state == SDone && rcnt == '0);
    end
  end
  always_ff @(posedge clk) begin
    if (state == SAddCk) begin
      add_res.kind <= (ins) ? stq_pkg::KindAdded : stq_pkg::KindRejected;
      add_res.timer_id_res <= id_m;
      add_res.due_time <= ins ? rq.expire_time : '0;
      add_res.rearmed <= 1'b0;
      add_res.new_earliest <= ins && (!cells[0].valid || rq.expire_time < cells[0].due);
      add_res.earliest_time <= '0;
      add_res.queue_empty <= 1'b0;
      add_res.is_last <= 1'b1;
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res = '0;
    if (add_r) begin
      res_valid = 1'b1;
      res = add_res;
      res.earliest_time = cells[0].valid ? cells[0].due : '0;
      res.queue_empty = !cells[0].valid;
    end else if (tick0_r) begin
      res_valid = 1'b1;
      res.kind = stq_pkg::KindNone;
      res.earliest_time = et_l;
      res.queue_empty = emp_l;
      res.is_last = 1'b1;
    end else if (rstate == RPlay) begin
      res_valid = 1'b1;
      res.kind = stq_pkg::KindExpired;
      res.timer_id_res = rbuf[0].id;
      res.due_time = rbuf[0].due;
      res.rearmed = rbuf[0].valid;
      res.earliest_time = et_l;
      res.queue_empty = emp_l;
      res.is_last = (rcnt == CW'(1));
    end
  end

  assign busy = (state != SIdle) || (rstate != RIdle) || add_r || tick0_r;

`ifndef ASSERT_OFF
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");
  a_one_res: assert property (@(posedge clk) disable iff (rst)
    $countones({add_r, tick0_r, rstate == RPlay}) <= 1)
    else $error("two result sources at once");
  a_head: assert property (@(posedge clk) disable iff (rst)
    !cells[0].valid |-> count == '0 || state != SIdle)
    else $error("empty head with entries pending");
`endif
endmodule
